>>> hw/rtl/elrc_pkg.sv
// Shared types and constants for the coalescing event log ring.
// No dependencies; elrc_ring_ctrl and the top level refer to this package by scoped names.
package elrc_pkg;

  // Default number of slots in the ring.
  localparam int LOG_DEPTH_DEF = 32;

  // Repeat counts stop rising at this value.
  localparam logic [7:0] REPEAT_LIMIT = 8'd250;

  // Width of the slot fields reported with every result.
  localparam int SLOT_W = 5;

  // Operation codes of an input item.
  typedef enum logic {
    OP_LOG  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // One input item as held in the input register.
  typedef struct packed {
    op_t         operation;
    logic [7:0]  event_code;
    logic [31:0] event_info;
    logic [31:0] event_time;
    logic [7:0]  read_index;
  } item_t;

  // One stored log entry, as kept in the RAM.
  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] info;
    logic [31:0] event_time;
    logic [7:0]  repeats;
  } entry_t;

endpackage

>>> hw/rtl/elrc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module elrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/elrc_ring_ctrl.sv
// Ring control: pointers, per-slot valid bits, a copy of the newest entry for
// coalescing, and the write and read requests to the entry RAM. Uses elrc_pkg.
module elrc_ring_ctrl #(
  parameter int LOG_DEPTH = elrc_pkg::LOG_DEPTH_DEF,
  localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  input  elrc_pkg::item_t       item,
  output logic                  wr_en,
  output logic [PTR_W-1:0]      wr_addr,
  output elrc_pkg::entry_t      wr_data,
  output logic                  rd_en,
  output logic [PTR_W-1:0]      rd_addr,
  output logic                  rd_hit,
  output logic [PTR_W-1:0]      oldest_ptr,
  output logic [PTR_W-1:0]      newest_ptr
);

  localparam logic [PTR_W:0] LAST     = (PTR_W+1)'(LOG_DEPTH - 1);
  localparam logic [7:0]     DEPTH_8  = 8'(LOG_DEPTH);

  logic [PTR_W-1:0]     oldest_r, oldest_nxt;
  logic [PTR_W-1:0]     newest_r, newest_nxt;
  logic [LOG_DEPTH-1:0] valid_r, valid_nxt;
  logic [7:0]           nw_code_r, nw_code_nxt;
  logic [31:0]          nw_info_r, nw_info_nxt;
  logic [7:0]           nw_rep_r, nw_rep_nxt;

  logic                 is_log;
  logic                 match;
  logic                 advance;
  logic [7:0]           rep_inc;
  logic [PTR_W:0]       n_ext;
  logic                 wrap;
  logic [PTR_W-1:0]     n_adv;
  logic [PTR_W:0]       o_ext;
  logic [PTR_W-1:0]     slot;

  // A log item with a non-zero code is the only thing that changes the ring.
  assign is_log  = item_vld && (item.operation == elrc_pkg::OP_LOG) &&
                   (item.event_code != 8'd0);
  assign match   = (nw_code_r == item.event_code) && (nw_info_r == item.event_info);
  assign advance = is_log && !match && valid_r[0];
  assign rep_inc = (nw_rep_r < elrc_pkg::REPEAT_LIMIT) ? nw_rep_r + 8'd1 : nw_rep_r;

  // Next newest slot and the oldest pointer it pushes along.
  always_comb begin
    n_ext = {1'b0, newest_r} + (PTR_W+1)'(1);
    wrap  = (n_ext > LAST);
    n_adv = wrap ? '0 : n_ext[PTR_W-1:0];
    o_ext = wrap ? (PTR_W+1)'(1) : {1'b0, oldest_r};
    if (o_ext == {1'b0, n_adv}) begin
      o_ext = o_ext + (PTR_W+1)'(1);
    end
    if (o_ext > LAST) begin
      o_ext = '0;
    end
  end

  assign slot = advance ? n_adv : newest_r;

  // Register updates and the RAM write for a log item.
  always_comb begin
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    valid_nxt   = valid_r;
    nw_code_nxt = nw_code_r;
    nw_info_nxt = nw_info_r;
    nw_rep_nxt  = nw_rep_r;
    wr_en       = 1'b0;
    wr_addr     = newest_r;
    wr_data.code       = item.event_code;
    wr_data.info       = item.event_info;
    wr_data.event_time = item.event_time;
    wr_data.repeats    = 8'd0;
    if (is_log) begin
      wr_en = 1'b1;
      if (match) begin
        // Duplicate of the newest entry: count it and refresh its time.
        wr_data.repeats = rep_inc;
        nw_rep_nxt      = rep_inc;
      end else begin
        // New entry in the next slot, or in slot 0 while the ring is empty.
        wr_addr         = slot;
        newest_nxt      = slot;
        if (advance) begin
          oldest_nxt = o_ext[PTR_W-1:0];
        end
        valid_nxt[slot] = 1'b1;
        nw_code_nxt     = item.event_code;
        nw_info_nxt     = item.event_info;
        nw_rep_nxt      = 8'd0;
      end
    end
  end

  // Read lookup: the slot must exist and hold an event.
  assign rd_en   = item_vld && (item.operation == elrc_pkg::OP_READ);
  assign rd_addr = item.read_index[PTR_W-1:0];
  assign rd_hit  = rd_en && (item.read_index < DEPTH_8) && valid_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      newest_r  <= '0;
      valid_r   <= '0;
      nw_code_r <= 8'd0;
    end else begin
      oldest_r  <= oldest_nxt;
      newest_r  <= newest_nxt;
      valid_r   <= valid_nxt;
      nw_code_r <= nw_code_nxt;
    end
  end

  // Payload copy of the newest entry; only compared once its code is set.
  always_ff @(posedge clk) begin
    nw_info_r <= nw_info_nxt;
    nw_rep_r  <= nw_rep_nxt;
  end

  assign oldest_ptr = oldest_r;
  assign newest_ptr = newest_r;

endmodule

>>> hw/rtl/event_log_ring_coalescing_top.sv
// Top level of the coalescing event log ring.
// Uses elrc_pkg, elrc_ring_ctrl and elrc_ram.

// The block takes one item in every clock cycle (busy is high only during
// reset) and gives exactly one result per item: the item first sits in the
// input register, where the ring control and RAM write or read address are
// worked out, and then passes through the RAM's registered read.
// out_strobe marks the result for a single cycle and cannot be held off.
// A log item reports only the oldest and newest slots as they stand after it;
// a read item also returns the stored entry, or zeros with out_entry_valid low
// if the index is out of range or the slot is empty. The store counts as empty
// straight after reset through per-slot valid flops, so no clearing pass runs.
module event_log_ring_coalescing_top #(
  parameter int LOG_DEPTH = elrc_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_event_code,
  input  logic [31:0] in_event_info,
  input  logic [31:0] in_event_time,
  input  logic [7:0]  in_read_index,
  output logic        out_strobe,
  output logic        out_entry_valid,
  output logic [7:0]  out_entry_code,
  output logic [31:0] out_entry_info,
  output logic [31:0] out_entry_time,
  output logic [7:0]  out_entry_repeats,
  output logic [elrc_pkg::SLOT_W-1:0] out_oldest_slot,
  output logic [elrc_pkg::SLOT_W-1:0] out_newest_slot
);

  localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  elrc_pkg::item_t  item_r, item_nxt;
  logic             item_vld_r;
  logic             out_vld_r;
  logic             rd_hit_r;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  elrc_pkg::entry_t wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_hit;
  logic [PTR_W-1:0] oldest_ptr;
  logic [PTR_W-1:0] newest_ptr;
  elrc_pkg::entry_t rd_data;

  // Every cycle outside reset can take an item.
  assign busy = !rst_n;

  // Input register.
  always_comb begin
    item_nxt.operation  = elrc_pkg::op_t'(in_operation);
    item_nxt.event_code = in_event_code;
    item_nxt.event_info = in_event_info;
    item_nxt.event_time = in_event_time;
    item_nxt.read_index = in_read_index;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // Item and result strobes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      rd_hit_r   <= 1'b0;
    end else begin
      item_vld_r <= start && !busy;
      out_vld_r  <= item_vld_r;
      rd_hit_r   <= rd_hit;
    end
  end

  elrc_ring_ctrl #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld_r),
    .item       (item_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_hit     (rd_hit),
    .oldest_ptr (oldest_ptr),
    .newest_ptr (newest_ptr)
  );

  elrc_ram #(
    .WIDTH ($bits(elrc_pkg::entry_t)),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result fields; entry fields are zero unless a read found an event.
  assign out_strobe        = out_vld_r;
  assign out_entry_valid   = rd_hit_r;
  assign out_entry_code    = rd_hit_r ? rd_data.code       : 8'd0;
  assign out_entry_info    = rd_hit_r ? rd_data.info       : 32'd0;
  assign out_entry_time    = rd_hit_r ? rd_data.event_time : 32'd0;
  assign out_entry_repeats = rd_hit_r ? rd_data.repeats    : 8'd0;

  // The pointers were updated at the edge that produced this result.
  assign out_oldest_slot = elrc_pkg::SLOT_W'(oldest_ptr);
  assign out_newest_slot = elrc_pkg::SLOT_W'(newest_ptr);

`ifndef SYNTH
  // Both pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((32'(oldest_ptr) < LOG_DEPTH) && (32'(newest_ptr) < LOG_DEPTH)))
    else $error("ring pointer beyond LOG_DEPTH");

  // A valid read never returns an empty code or an over-limit count.
  a_valid_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_entry_valid |-> (out_entry_code != 8'd0) &&
                        (out_entry_repeats <= elrc_pkg::REPEAT_LIMIT))
    else $error("valid entry with empty code or repeat overflow");

  // A read hit at the lookup is followed in the next cycle by a result strobe with a valid entry.
  a_hit_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_hit |=> out_strobe && out_entry_valid)
    else $error("read hit lost between lookup and result");
`endif

endmodule
